// ===== rtl/dsrt_pkg.sv =====
package dsrt_pkg;

   // buffer size default and fixed field widths
   localparam int BUFFER_BYTES_DEFAULT = 16384;
   localparam int SEQ_W                = 31;
   localparam int FLEN_W               = 16;
   localparam int AVAIL_W              = 11;
   localparam int MSG_W                = 15;
   localparam int SKIP_W               = 16;
   localparam int SUM_W                = 17;
   localparam int CSR_INDEX_W          = 2;
   localparam int CSR_DATA_W           = 16;
   localparam int QUEUE_DEPTH          = 2;

   // verdict codes
   localparam logic [2:0] VERDICT_DELIVER      = 3'd0;
   localparam logic [2:0] VERDICT_BAD_CHECKSUM = 3'd1;
   localparam logic [2:0] VERDICT_STALE        = 3'd2;
   localparam logic [2:0] VERDICT_GAP          = 3'd3;
   localparam logic [2:0] VERDICT_ILLEGAL_LEN  = 3'd4;
   localparam logic [2:0] VERDICT_HELD         = 3'd5;
   localparam logic [2:0] VERDICT_OVERSIZE     = 3'd6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECKSUM_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAGMENT_SIZE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_MESSAGE     = 2'd2;

   // register reset values
   localparam logic              CHECKSUM_ENABLE_RESET = 1'b1;
   localparam logic [FLEN_W-1:0] FRAGMENT_SIZE_RESET   = 16'd1300;
   localparam logic [MSG_W-1:0]  MAX_MESSAGE_RESET     = 15'd16384;

   localparam logic [SKIP_W-1:0] SKIP_MAX = 16'hFFFF;

   // classified request as held in the queue
   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic              frag;
      logic              csum_fail;
      logic [31:0]       frag_start;
      logic [FLEN_W-1:0] frag_length;
      logic              len_over_avail;
   } dsrt_item_type;

   typedef struct packed {
      logic          valid;
      dsrt_item_type item;
   } dsrt_head_type;

   typedef struct packed {
      logic              full;
      logic              empty;
   } dsrt_qstat_type;

   typedef struct packed {
      logic [FLEN_W-1:0] full_frag_len;
      logic [MSG_W-1:0]  max_message_size;
   } dsrt_cfg_type;

endpackage

// ===== rtl/dsrt_front.sv =====
module dsrt_front (
   input  logic [31:0]                    req_header_word,
   input  logic                           req_checksum_ok,
   input  logic signed [31:0]             req_frag_start,
   input  logic [dsrt_pkg::FLEN_W-1:0]    req_frag_length,
   input  logic [dsrt_pkg::AVAIL_W-1:0]   req_bytes_available,
   input  logic                           checksum_check_enable,
   output dsrt_pkg::dsrt_item_type        item
);

   // state-free checks are settled here, ahead of the queue
   always_comb begin
      item.seq            = req_header_word[30:0];
      item.frag           = req_header_word[31];
      item.csum_fail      = checksum_check_enable && !req_checksum_ok;
      item.frag_start     = req_frag_start;
      item.frag_length    = req_frag_length;
      item.len_over_avail =
         req_frag_length > dsrt_pkg::FLEN_W'(req_bytes_available);
   end

endmodule

// ===== rtl/dsrt_queue.sv =====
module dsrt_queue #(
   parameter int DEPTH = dsrt_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dsrt_pkg::dsrt_item_type item_in,
   input  logic                    pop,
   output dsrt_pkg::dsrt_head_type head,
   output dsrt_pkg::dsrt_qstat_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   dsrt_pkg::dsrt_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head.valid   = count_ff != '0;
   assign head.item    = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff == FULL_CNT;
   assign status.empty = count_ff == '0;

endmodule

// ===== rtl/dsrt_back.sv =====
module dsrt_back #(
   parameter int BUFFER_BYTES = dsrt_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dsrt_pkg::dsrt_cfg_type        cfg,
   input  dsrt_pkg::dsrt_head_type       head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_verdict,
   output logic [dsrt_pkg::SEQ_W-1:0]    rsp_packet_sequence,
   output logic [dsrt_pkg::MSG_W-1:0]    rsp_store_offset,
   output logic [dsrt_pkg::MSG_W-1:0]    rsp_message_length,
   output logic [dsrt_pkg::SKIP_W-1:0]   rsp_dropped_count
);

   localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
   localparam logic [dsrt_pkg::SUM_W-1:0] BUF_LIMIT = dsrt_pkg::SUM_W'(BUFFER_BYTES);

   logic [dsrt_pkg::SEQ_W-1:0]  last_seq_ff, last_seq_in;
   logic [dsrt_pkg::SEQ_W-1:0]  frag_seq_ff, frag_seq_in;
   logic [LEN_W-1:0]            asm_len_ff, asm_len_in;
   logic [dsrt_pkg::SKIP_W-1:0] skipped_ff, skipped_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [2:0]                  verdict_ff, verdict_in;
   logic [dsrt_pkg::SEQ_W-1:0]  seq_ff;
   logic [dsrt_pkg::MSG_W-1:0]  offset_ff, offset_in;
   logic [dsrt_pkg::MSG_W-1:0]  msglen_ff, msglen_in;

   dsrt_pkg::dsrt_item_type     it;
   logic                        take;
   logic [dsrt_pkg::SEQ_W-1:0]  gap;
   logic [LEN_W-1:0]            base_len;
   logic [dsrt_pkg::SUM_W-1:0]  base_ext;
   logic [dsrt_pkg::SUM_W-1:0]  sum;

   assign it   = head.item;
   assign take = head.valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = take;

   always_comb begin
      last_seq_in  = last_seq_ff;
      frag_seq_in  = frag_seq_ff;
      asm_len_in   = asm_len_ff;
      skipped_in   = skipped_ff;
      verdict_in   = dsrt_pkg::VERDICT_DELIVER;
      offset_in    = '0;
      msglen_in    = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      gap      = it.seq - last_seq_ff - 1'b1;
      base_len = (it.seq != frag_seq_ff) ? '0 : asm_len_ff;
      base_ext = dsrt_pkg::SUM_W'(base_len);
      sum      = base_ext + dsrt_pkg::SUM_W'(it.frag_length);

      if (it.csum_fail) begin
         verdict_in = dsrt_pkg::VERDICT_BAD_CHECKSUM;
      end else if (it.seq <= last_seq_ff) begin
         verdict_in = dsrt_pkg::VERDICT_STALE;
      end else begin
         skipped_in = (|gap[30:16]) ? dsrt_pkg::SKIP_MAX : gap[15:0];
         if (!it.frag) begin
            last_seq_in = it.seq;
         end else begin
            // a new fragment sequence restarts the message
            frag_seq_in = it.seq;
            asm_len_in  = base_len;
            offset_in   = base_ext[dsrt_pkg::MSG_W-1:0];
            if (it.frag_start != 32'(base_len)) begin
               verdict_in = dsrt_pkg::VERDICT_GAP;
            end else if (it.len_over_avail || sum > BUF_LIMIT) begin
               verdict_in = dsrt_pkg::VERDICT_ILLEGAL_LEN;
            end else begin
               asm_len_in = LEN_W'(sum);
               if (it.frag_length == cfg.full_frag_len) begin
                  verdict_in = dsrt_pkg::VERDICT_HELD;
               end else if (sum > dsrt_pkg::SUM_W'(cfg.max_message_size)) begin
                  verdict_in = dsrt_pkg::VERDICT_OVERSIZE;
               end else begin
                  msglen_in   = sum[dsrt_pkg::MSG_W-1:0];
                  asm_len_in  = '0;
                  last_seq_in = it.seq;
               end
            end
         end
      end
      if (take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff  <= '0;
         frag_seq_ff  <= '0;
         asm_len_ff   <= '0;
         skipped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            last_seq_ff <= last_seq_in;
            frag_seq_ff <= frag_seq_in;
            asm_len_ff  <= asm_len_in;
            skipped_ff  <= skipped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         verdict_ff <= verdict_in;
         seq_ff     <= it.seq;
         offset_ff  <= offset_in;
         msglen_ff  <= msglen_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = verdict_ff;
   assign rsp_packet_sequence = seq_ff;
   assign rsp_store_offset    = offset_ff;
   assign rsp_message_length  = msglen_ff;
   assign rsp_dropped_count   = skipped_ff;

endmodule

// ===== rtl/datagram_sequence_reassembly_tracker_core.sv =====
// sequenced datagram fragment tracker
//
// req_* carries one parsed packet header per request (valid/ready). the
// front stage settles the checks that need no state and writes the request
// into a two-entry queue; the back stage takes one request a cycle from the
// queue while the result register is free or being read, runs the sequence
// and fragment checks against its state and loads the result register that
// drives rsp_* (valid/ready). a request is registered in the queue entry and
// then in the result register before it shows on rsp_*. throughput: one
// request per cycle, limited by the state update in the back stage.
// when rsp_ready is low the result register holds, the back stage stops
// draining and req_ready falls only once both queue entries are taken.
// csr_* writes go straight into the configuration registers, one per
// cycle, and are meant to happen while the block is idle.
// reset clears the sequence state, the dropped count, the queue and the
// result valid flag, and sets the configuration registers to their defaults
module datagram_sequence_reassembly_tracker_core #(
   parameter int BUFFER_BYTES = dsrt_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [31:0]                        req_header_word,
   input  logic                               req_checksum_ok,
   input  logic signed [31:0]                 req_frag_start,
   input  logic [dsrt_pkg::FLEN_W-1:0]        req_frag_length,
   input  logic [dsrt_pkg::AVAIL_W-1:0]       req_bytes_available,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_verdict,
   output logic [dsrt_pkg::SEQ_W-1:0]         rsp_packet_sequence,
   output logic [dsrt_pkg::MSG_W-1:0]         rsp_store_offset,
   output logic [dsrt_pkg::MSG_W-1:0]         rsp_message_length,
   output logic [dsrt_pkg::SKIP_W-1:0]        rsp_dropped_count,
   // configuration write port
   input  logic                               csr_write_enable,
   input  logic [dsrt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dsrt_pkg::CSR_DATA_W-1:0]    csr_data
);

   // configuration registers
   logic                          csum_en_ff;
   logic [dsrt_pkg::FLEN_W-1:0]   frag_size_ff;
   logic [dsrt_pkg::MSG_W-1:0]    max_msg_ff;

   dsrt_pkg::dsrt_item_type   front_item;
   dsrt_pkg::dsrt_head_type   q_head;
   dsrt_pkg::dsrt_qstat_type  q_status;
   dsrt_pkg::dsrt_cfg_type    back_cfg;
   logic                      q_push;
   logic                      q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         csum_en_ff   <= dsrt_pkg::CHECKSUM_ENABLE_RESET;
         frag_size_ff <= dsrt_pkg::FRAGMENT_SIZE_RESET;
         max_msg_ff   <= dsrt_pkg::MAX_MESSAGE_RESET;
      end else if (csr_write_enable) begin
         // out-of-range indexes are dropped
         unique case (csr_index)
            dsrt_pkg::CSR_CHECKSUM_ENABLE: csum_en_ff   <= csr_data[0];
            dsrt_pkg::CSR_FRAGMENT_SIZE:   frag_size_ff <= csr_data;
            dsrt_pkg::CSR_MAX_MESSAGE:     max_msg_ff   <= csr_data[dsrt_pkg::MSG_W-1:0];
            default: ;
         endcase
      end
   end

   assign back_cfg.full_frag_len    = frag_size_ff;
   assign back_cfg.max_message_size = max_msg_ff;

   // front: stateless classification
   dsrt_front u_front (
      .req_header_word       (req_header_word),
      .req_checksum_ok       (req_checksum_ok),
      .req_frag_start        (req_frag_start),
      .req_frag_length       (req_frag_length),
      .req_bytes_available   (req_bytes_available),
      .checksum_check_enable (csum_en_ff),
      .item                  (front_item)
   );

   // ready follows queue space only, so a stalled result never blocks intake
   // until the queue has filled
   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   dsrt_queue #(
      .DEPTH (dsrt_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .item_in (front_item),
      .pop     (q_pop),
      .head    (q_head),
      .status  (q_status)
   );

   // back: stateful checks and the result register
   dsrt_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (back_cfg),
      .head                (q_head),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_verdict         (rsp_verdict),
      .rsp_packet_sequence (rsp_packet_sequence),
      .rsp_store_offset    (rsp_store_offset),
      .rsp_message_length  (rsp_message_length),
      .rsp_dropped_count   (rsp_dropped_count)
   );

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // a message length is only reported on delivery
   a_msglen_on_deliver: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_message_length != '0) |-> rsp_verdict == dsrt_pkg::VERDICT_DELIVER)
      else $error("message length on a non-delivery verdict");

   // rejected before the fragment logic: no offset and no length
   a_early_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_verdict == dsrt_pkg::VERDICT_BAD_CHECKSUM ||
                     rsp_verdict == dsrt_pkg::VERDICT_STALE))
      |-> (rsp_store_offset == '0 && rsp_message_length == '0))
      else $error("offset or length on an early rejection");

   // the back stage never pulls from an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from an empty queue");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

class reassembly_scoreboard;
   typedef struct {
      logic [2:0]                  verdict;
      logic [dsrt_pkg::SEQ_W-1:0]  packet_sequence;
      logic [dsrt_pkg::MSG_W-1:0]  store_offset;
      logic [dsrt_pkg::MSG_W-1:0]  message_length;
      logic [dsrt_pkg::SKIP_W-1:0] dropped_count;
   } verdict_record;

   int unsigned               buffer_bytes;
   // register copies
   bit                        checksum_enable;
   bit [dsrt_pkg::FLEN_W-1:0] full_frag_len;
   bit [dsrt_pkg::MSG_W-1:0]  max_message;
   // tracker state
   bit [dsrt_pkg::SEQ_W-1:0]  last_sequence;
   bit [dsrt_pkg::SEQ_W-1:0]  fragment_sequence;
   int unsigned               assembled;
   bit [dsrt_pkg::SKIP_W-1:0] skipped;

   verdict_record   awaited[$];
   int              mismatches;
   int              requests_seen;
   int              verdict_tally[7];

   function new(int unsigned buffer_size);
      buffer_bytes      = buffer_size;
      checksum_enable   = dsrt_pkg::CHECKSUM_ENABLE_RESET;
      full_frag_len     = dsrt_pkg::FRAGMENT_SIZE_RESET;
      max_message       = dsrt_pkg::MAX_MESSAGE_RESET;
      last_sequence     = '0;
      fragment_sequence = '0;
      assembled         = 0;
      skipped           = '0;
      mismatches        = 0;
      requests_seen     = 0;
      foreach (verdict_tally[i]) verdict_tally[i] = 0;
   endfunction

   function void set_register(logic [dsrt_pkg::CSR_INDEX_W-1:0] index,
                              logic [dsrt_pkg::CSR_DATA_W-1:0] data);
      case (index)
         dsrt_pkg::CSR_CHECKSUM_ENABLE: checksum_enable = data[0];
         dsrt_pkg::CSR_FRAGMENT_SIZE:   full_frag_len   = data[dsrt_pkg::FLEN_W-1:0];
         dsrt_pkg::CSR_MAX_MESSAGE:     max_message     = data[dsrt_pkg::MSG_W-1:0];
         default: ;
      endcase
   endfunction

   function void note_request(logic [31:0] word, logic csum_ok, logic signed [31:0] start,
                              logic [dsrt_pkg::FLEN_W-1:0] flen,
                              logic [dsrt_pkg::AVAIL_W-1:0] avail);
      verdict_record            want;
      bit [dsrt_pkg::SEQ_W-1:0] seq;
      int unsigned              gap;
      seq                  = word[dsrt_pkg::SEQ_W-1:0];
      want.verdict         = dsrt_pkg::VERDICT_DELIVER;
      want.packet_sequence = seq;
      want.store_offset    = '0;
      want.message_length  = '0;
      if (checksum_enable && !csum_ok) begin
         want.verdict = dsrt_pkg::VERDICT_BAD_CHECKSUM;
      end else if (seq <= last_sequence) begin
         want.verdict = dsrt_pkg::VERDICT_STALE;
      end else begin
         gap     = 32'(seq) - 32'(last_sequence) - 1;
         skipped = (gap > 32'(dsrt_pkg::SKIP_MAX)) ? dsrt_pkg::SKIP_MAX
                                                   : gap[dsrt_pkg::SKIP_W-1:0];
         if (!word[31]) begin
            last_sequence = seq;
         end else begin
            if (seq != fragment_sequence) begin
               fragment_sequence = seq;
               assembled         = 0;
            end
            want.store_offset = assembled[dsrt_pkg::MSG_W-1:0];
            if (start[31] || $unsigned(start) != assembled) begin
               want.verdict = dsrt_pkg::VERDICT_GAP;
            end else if (32'(flen) > 32'(avail) || assembled + 32'(flen) > buffer_bytes) begin
               want.verdict = dsrt_pkg::VERDICT_ILLEGAL_LEN;
            end else begin
               assembled += 32'(flen);
               if (flen == full_frag_len) begin
                  want.verdict = dsrt_pkg::VERDICT_HELD;
               end else if (assembled > 32'(max_message)) begin
                  want.verdict = dsrt_pkg::VERDICT_OVERSIZE;
               end else begin
                  want.message_length = assembled[dsrt_pkg::MSG_W-1:0];
                  assembled           = 0;
                  last_sequence       = seq;
               end
            end
         end
      end
      want.dropped_count = skipped;
      awaited.push_back(want);
      requests_seen++;
      verdict_tally[want.verdict]++;
   endfunction

   function void check_result(logic [2:0] verdict, logic [dsrt_pkg::SEQ_W-1:0] seq,
                              logic [dsrt_pkg::MSG_W-1:0] offset,
                              logic [dsrt_pkg::MSG_W-1:0] msg_len,
                              logic [dsrt_pkg::SKIP_W-1:0] dropped);
      verdict_record want;
      if (awaited.size() == 0) begin
         $error("result with no request outstanding: verdict %0d sequence %0d", verdict, seq);
         mismatches++;
         return;
      end
      want = awaited.pop_front();
      if (verdict !== want.verdict) begin
         $error("verdict: expected %0d, got %0d", want.verdict, verdict);
         mismatches++;
      end
      if (seq !== want.packet_sequence) begin
         $error("packet_sequence: expected %0d, got %0d", want.packet_sequence, seq);
         mismatches++;
      end
      if (offset !== want.store_offset) begin
         $error("store_offset: expected %0d, got %0d", want.store_offset, offset);
         mismatches++;
      end
      if (msg_len !== want.message_length) begin
         $error("message_length: expected %0d, got %0d", want.message_length, msg_len);
         mismatches++;
      end
      if (dropped !== want.dropped_count) begin
         $error("dropped_count: expected %0d, got %0d", want.dropped_count, dropped);
         mismatches++;
      end
   endfunction
endclass

module tb_top;
   localparam int BUFFER_BYTES     = dsrt_pkg::BUFFER_BYTES_DEFAULT;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int HOLD_OFF_CYCLES  = 60;
   localparam int RANDOM_PER_PHASE = 125;
   localparam int SETTLE_CYCLES    = 4;
   localparam int PHASES           = 6;
   localparam int MAX_AVAIL        = 1400;
   localparam logic [dsrt_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [31:0]                      FRAG_BIT         = 32'h8000_0000;
   localparam logic [dsrt_pkg::SEQ_W-1:0]       SEQ_TOP          = '1;

   // register settings per phase, extremes included
   bit                        phase_checksum [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
   bit [dsrt_pkg::FLEN_W-1:0] phase_frag_size[PHASES] = '{16'd1300, 16'd64, 16'd1, 16'd65535,
                                                          16'd1400, 16'd512};
   bit [dsrt_pkg::MSG_W-1:0]  phase_max_msg  [PHASES] = '{15'd16384, 15'd1000, 15'd0,
                                                          15'd16384, 15'd5000, 15'd16384};

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [31:0]                      req_header_word = '0;
   logic                             req_checksum_ok = 1'b0;
   logic signed [31:0]               req_frag_start = '0;
   logic [dsrt_pkg::FLEN_W-1:0]      req_frag_length = '0;
   logic [dsrt_pkg::AVAIL_W-1:0]     req_bytes_available = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [2:0]                       rsp_verdict;
   logic [dsrt_pkg::SEQ_W-1:0]       rsp_packet_sequence;
   logic [dsrt_pkg::MSG_W-1:0]       rsp_store_offset;
   logic [dsrt_pkg::MSG_W-1:0]       rsp_message_length;
   logic [dsrt_pkg::SKIP_W-1:0]      rsp_dropped_count;
   logic                             csr_write_enable = 1'b0;
   logic [dsrt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [dsrt_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   reassembly_scoreboard board;
   bit  idle_enabled   = 1'b0;   // random idling on both sides
   bit  hold_off_armed = 1'b0;   // one long result stall on request
   int  cycle_count    = 0;
   int  stall_left     = 0;

   datagram_sequence_reassembly_tracker_core #(.BUFFER_BYTES(BUFFER_BYTES)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result monitor, sampled before the edge's updates land
   always @(posedge clock)
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_result(rsp_verdict, rsp_packet_sequence, rsp_store_offset,
                            rsp_message_length, rsp_dropped_count);

   // result receiver: short random stalls, plus one long hold-off so that
   // the queue fills and the request side backs up
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_armed) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_armed = 1'b0;
         end
         if (stall_left == 0 && idle_enabled && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
         if (stall_left != 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // offer one request and hold it until taken; entered and left at a falling edge
   task automatic send_request(logic [31:0] word, logic csum_ok, logic signed [31:0] start,
                               logic [dsrt_pkg::FLEN_W-1:0] flen,
                               logic [dsrt_pkg::AVAIL_W-1:0] avail);
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid           = 1'b1;
      req_header_word     = word;
      req_checksum_ok     = csum_ok;
      req_frag_start      = start;
      req_frag_length     = flen;
      req_bytes_available = avail;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_request(word, csum_ok, start, flen, avail);
      @(negedge clock);
   endtask

   // drain everything outstanding, then let the pipeline settle
   task automatic wait_idle();
      req_valid = 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [dsrt_pkg::CSR_INDEX_W-1:0] index,
                                 logic [dsrt_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_data         = data;
      board.set_register(index, data);
      @(negedge clock);
   endtask

   task automatic configure(bit enable, bit [dsrt_pkg::FLEN_W-1:0] frag_size,
                            bit [dsrt_pkg::MSG_W-1:0] max_msg, bit poke_unused);
      wait_idle();
      write_register(dsrt_pkg::CSR_CHECKSUM_ENABLE, dsrt_pkg::CSR_DATA_W'(enable));
      write_register(dsrt_pkg::CSR_FRAGMENT_SIZE, frag_size);
      write_register(dsrt_pkg::CSR_MAX_MESSAGE, dsrt_pkg::CSR_DATA_W'(max_msg));
      // an unused index must leave every register alone
      if (poke_unused) write_register(CSR_UNUSED_INDEX, '0);
      csr_write_enable = 1'b0;
   endtask

   // mostly well-formed fragment trains against the tracker's current state,
   // with some stale, broken and pure noise requests mixed in
   task automatic random_request();
      int                           pick;
      int unsigned                  skip;
      bit                           open;
      bit [dsrt_pkg::SEQ_W-1:0]     seq;
      logic [31:0]                  word;
      logic                         csum_ok;
      logic signed [31:0]           start;
      logic [dsrt_pkg::FLEN_W-1:0]  flen;
      logic [dsrt_pkg::AVAIL_W-1:0] avail;
      pick    = $urandom_range(0, 99);
      skip    = ($urandom_range(0, 39) == 0) ? $urandom_range(65535, 150000)
                                             : $urandom_range(0, 2);
      open    = board.fragment_sequence > board.last_sequence;
      csum_ok = ($urandom_range(0, 11) != 0);
      // full-size fragment most of the time, else a closing one
      if ($urandom_range(0, 9) < 7) flen = board.full_frag_len;
      else                          flen = dsrt_pkg::FLEN_W'($urandom_range(0, MAX_AVAIL));
      avail = (flen > dsrt_pkg::FLEN_W'(MAX_AVAIL))
              ? dsrt_pkg::AVAIL_W'(MAX_AVAIL)
              : dsrt_pkg::AVAIL_W'($urandom_range(flen, MAX_AVAIL));
      start = board.assembled;
      seq   = dsrt_pkg::SEQ_W'(board.last_sequence + 1 + skip);
      if (pick < 45 && open) begin
         // next fragment of the message in progress
         word = FRAG_BIT | 32'(board.fragment_sequence);
      end else if (pick < 65) begin
         // first fragment of a new message
         word  = FRAG_BIT | 32'(seq);
         start = 0;
      end else if (pick < 80) begin
         word = 32'(seq);
      end else if (pick < 85) begin
         // stale or duplicate sequence
         word = {1'($urandom_range(0, 1)),
                 dsrt_pkg::SEQ_W'($urandom_range(0, board.last_sequence))};
      end else if (pick < 92) begin
         // broken fragment: wrong offset, negative offset or overlong length
         word = FRAG_BIT | 32'(open ? board.fragment_sequence : seq);
         if (!open) start = 0;
         case ($urandom_range(0, 2))
            0: start = start + $urandom_range(1, 2000);
            1: start = $signed({1'b1, 31'($urandom)});
            default: begin
               flen  = dsrt_pkg::FLEN_W'($urandom_range(1, 65535));
               avail = (flen > dsrt_pkg::FLEN_W'(MAX_AVAIL))
                       ? dsrt_pkg::AVAIL_W'($urandom_range(0, MAX_AVAIL))
                       : dsrt_pkg::AVAIL_W'($urandom_range(0, flen - 1));
            end
         endcase
      end else begin
         // noise; anything that gets past the checksum stays near the current sequence
         word    = $urandom;
         start   = $urandom;
         flen    = dsrt_pkg::FLEN_W'($urandom);
         avail   = dsrt_pkg::AVAIL_W'($urandom_range(0, MAX_AVAIL));
         csum_ok = 1'($urandom_range(0, 1));
         if (!board.checksum_enable || csum_ok)
            word[dsrt_pkg::SEQ_W-1:0] =
               dsrt_pkg::SEQ_W'(board.last_sequence + $urandom_range(0, 3));
      end
      send_request(word, csum_ok, start, flen, avail);
   endtask

   initial begin
      board = new(BUFFER_BYTES);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset        = 1'b0;
      idle_enabled = 1'b1;

      // directed, reset register values
      send_request(32'd1, 1'b1, 0, 16'd10, 11'd10);                 // plain delivery
      send_request(32'd1, 1'b1, 0, 16'd0, 11'd0);                   // duplicate, stale
      send_request(32'hFFFF_FFFF, 1'b0, -1, 16'hFFFF, 11'd1400);    // bad checksum
      send_request(FRAG_BIT | 32'd3, 1'b1, 32'sh8000_0000, 16'd100, 11'd100); // negative start
      send_request(FRAG_BIT | 32'd3, 1'b1, 0, 16'd200, 11'd100);   // longer than packet
      for (int k = 0; k < 12; k++)
         send_request(FRAG_BIT | 32'd3, 1'b1, k * 1300, 16'd1300, 11'd1400);
      send_request(FRAG_BIT | 32'd3, 1'b1, 15600, 16'd1400, 11'd1400); // buffer overflow
      send_request(FRAG_BIT | 32'd3, 1'b1, 15600, 16'd784, 11'd1400);  // exactly a full buffer
      send_request(32'd70004, 1'b1, 0, 16'd0, 11'd0);               // dropped count saturates
      send_request(FRAG_BIT | 32'd70005, 1'b1, 0, 16'd0, 11'd0);    // empty fragmented message

      // directed, legacy mode and a tiny message limit
      configure(1'b0, 16'd100, 15'd150, 1'b0);
      send_request(FRAG_BIT | 32'd70006, 1'b0, 0, 16'd100, 11'd100);   // held, checksum ignored
      send_request(FRAG_BIT | 32'd70006, 1'b1, 100, 16'd60, 11'd60);   // oversize
      send_request(FRAG_BIT | 32'd70006, 1'b1, 99, 16'd60, 11'd60);    // gap, partial kept
      send_request(32'd0, 1'b0, 0, 16'd0, 11'd0);                       // stale

      // random phases, one register setting each
      for (int p = 0; p < PHASES; p++) begin
         configure(phase_checksum[p], phase_frag_size[p], phase_max_msg[p], p == 2);
         idle_enabled = (p != 2) && (p != PHASES - 1);
         if (p == 1) hold_off_armed = 1'b1;
         // last phase runs near the top of the sequence space
         if (p == PHASES - 1) send_request(32'h7FFF_0000, 1'b1, 0, 16'd0, 11'd0);
         repeat (RANDOM_PER_PHASE) random_request();
      end
      send_request({1'b0, SEQ_TOP}, 1'b1, 0, 16'd0, 11'd0);        // highest sequence
      send_request({1'b1, SEQ_TOP}, 1'b1, 0, 16'd0, 11'd0);        // nothing newer exists

      req_valid = 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (2 * SETTLE_CYCLES) @(negedge clock);

      $display("run covered %0d requests over %0d register settings, one long result stall",
               board.requests_seen, PHASES + 2);
      $display("verdicts: deliver %0d, bad checksum %0d, stale %0d, gap %0d",
               board.verdict_tally[dsrt_pkg::VERDICT_DELIVER],
               board.verdict_tally[dsrt_pkg::VERDICT_BAD_CHECKSUM],
               board.verdict_tally[dsrt_pkg::VERDICT_STALE],
               board.verdict_tally[dsrt_pkg::VERDICT_GAP]);
      $display("verdicts: illegal length %0d, held %0d, oversize %0d",
               board.verdict_tally[dsrt_pkg::VERDICT_ILLEGAL_LEN],
               board.verdict_tally[dsrt_pkg::VERDICT_HELD],
               board.verdict_tally[dsrt_pkg::VERDICT_OVERSIZE]);
      if (board.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
